[rtl/isaac_pkg.sv]
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared types and constants for the ISAAC generator core.
// ----------------------------------------------------------------------------
package isaac_pkg;

    localparam int WORD_COUNT = 256;
    localparam int IDX_W      = $clog2(WORD_COUNT);
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_INIT = 2'd1;
    localparam logic [1:0] REQ_GEN  = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_OUT,
        S_PRE_MIX,
        S_MP_RD,
        S_MP_RDW,
        S_MP_ADD,
        S_MP_MIX,
        S_MP_WR,
        S_G_START,
        S_G_X,
        S_G_XW,
        S_G_H,
        S_G_HW,
        S_G_Y,
        S_G_YW
    } t_state;

    // one step of the eight-word mixing function, step 0..7
    function automatic logic [255:0] mix_step(input logic [255:0] v, input logic [2:0] s);
        logic [31:0] w [8];
        logic [2:0] a, b, c, d;
        logic [31:0] t;
        for (int k = 0; k < 8; k++) w[k] = v[k*32 +: 32];
        a = s; b = s + 3'd1; c = s + 3'd2; d = s + 3'd3;
        case (s)
            3'd0: t = w[b] << 11;
            3'd1: t = w[b] >> 2;
            3'd2: t = w[b] << 8;
            3'd3: t = w[b] >> 16;
            3'd4: t = w[b] << 10;
            3'd5: t = w[b] >> 4;
            3'd6: t = w[b] << 8;
            default: t = w[b] >> 9;
        endcase
        w[a] = w[a] ^ t;
        w[d] = w[d] + w[a];
        w[b] = w[b] + w[c];
        for (int k = 0; k < 8; k++) mix_step[k*32 +: 32] = w[k];
    endfunction

endpackage

[rtl/isaac_ram.sv]
// ----------------------------------------------------------------------------
// isaac_ram
// Single-port 32-bit word memory with registered read data.
// ----------------------------------------------------------------------------
module isaac_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [isaac_pkg::IDX_W-1:0] i_addr,
    input  logic [31:0]                i_wdata,
    output logic [31:0]                o_rdata
);
    logic [31:0] r_mem [isaac_pkg::WORD_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/isaac_random_generator_core.sv]
// ----------------------------------------------------------------------------
// isaac_random_generator_core
// ISAAC generator: seed load, initialize, generation round, result read.
// ----------------------------------------------------------------------------
// One request at a time. A load passes through S_OUT and a read through
// S_READ and S_OUT to the result; the input is ready again in the cycle
// after the result is taken. A generation round runs S_G_START, then for each
// entry four reads and one write of the single-port mixing memory with
// registered read data. Initialize first runs the key mixing, then two
// passes of WORD_COUNT/8 groups (eight memory reads, eight mixing steps,
// eight writes), then one round. After reset a clearing pass zeroes both
// memories; no request is taken meanwhile. The result is held in an output
// register until taken.
module isaac_random_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // word_index[7:0], word_value[39:8]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // rand_word[31:0]
    output logic [1:0]  m_axis_tuser   // done_kind[1:0]
);
    localparam int W = isaac_pkg::IDX_W;

    isaac_pkg::t_state r_state, n_state;
    logic [W:0]    r_clr, n_clr;
    logic [W-1:0]  r_i, n_i;
    logic [3:0]    r_j, n_j;
    logic          r_pass, n_pass;
    logic [1:0]    r_kind, n_kind;
    logic [255:0]  r_iw, n_iw;
    logic [31:0]   r_a, n_a, r_b, n_b, r_cnt, n_cnt, r_x, n_x, r_y, n_y;
    logic          r_ov, n_ov;
    logic [31:0]   r_od, n_od;
    logic [1:0]    r_ok, n_ok;

    logic          m_we, s_we;
    logic [W-1:0]  m_addr, s_addr;
    logic [31:0]   m_wd, s_wd, m_rd, s_rd;

    isaac_ram u_mix (.i_clk, .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m_rd));
    isaac_ram u_res (.i_clk, .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wd), .o_rdata(s_rd));

    logic [W-1:0] w_group;
    logic [31:0]  w_a1;
    assign w_group = r_i + W'(r_j[2:0]);

    always_comb begin
        case (r_i[1:0])
            2'd0: w_a1 = r_a ^ (r_a << 13);
            2'd1: w_a1 = r_a ^ (r_a >> 6);
            2'd2: w_a1 = r_a ^ (r_a << 2);
            default: w_a1 = r_a ^ (r_a >> 16);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isaac_pkg::S_IDLE;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_a     <= n_a;
            r_b     <= n_b;
            r_cnt   <= n_cnt;
        end
        r_i <= n_i; r_j <= n_j; r_pass <= n_pass; r_kind <= n_kind;
        r_iw <= n_iw; r_x <= n_x; r_y <= n_y;
        r_od <= n_od; r_ok <= n_ok;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_i = r_i; n_j = r_j; n_pass = r_pass;
        n_kind = r_kind; n_iw = r_iw;
        n_a = r_a; n_b = r_b; n_cnt = r_cnt; n_x = r_x; n_y = r_y;
        n_ov = r_ov; n_od = r_od; n_ok = r_ok;
        m_we = 1'b0; s_we = 1'b0; m_addr = r_i; s_addr = r_i; m_wd = '0; s_wd = '0;
        s_axis_tready = 1'b0;
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        case (r_state)
            isaac_pkg::S_IDLE: begin
                if (!r_clr[W]) begin
                    m_we = 1'b1; s_we = 1'b1;
                    m_addr = r_clr[W-1:0]; s_addr = r_clr[W-1:0];
                    n_clr = r_clr + 1'b1;
                end else if (!r_ov) begin
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid) begin
                        n_kind = s_axis_tuser;
                        case (s_axis_tuser)
                            isaac_pkg::REQ_LOAD: begin
                                s_we = 1'b1; s_addr = s_axis_tdata[W-1:0];
                                s_wd = s_axis_tdata[39:8];
                                n_od = '0; n_state = isaac_pkg::S_OUT;
                            end
                            isaac_pkg::REQ_INIT: begin
                                n_a = '0; n_b = '0; n_cnt = '0;
                                n_iw = {8{isaac_pkg::GOLDEN}};
                                n_i = '0; n_j = '0; n_state = isaac_pkg::S_PRE_MIX;
                            end
                            isaac_pkg::REQ_GEN: n_state = isaac_pkg::S_G_START;
                            default: begin
                                s_addr = s_axis_tdata[W-1:0];
                                n_state = isaac_pkg::S_READ;
                            end
                        endcase
                    end
                end
            end
            isaac_pkg::S_READ: begin
                n_od = s_rd; n_state = isaac_pkg::S_OUT;
            end
            isaac_pkg::S_OUT: begin
                if (r_kind != isaac_pkg::REQ_READ) n_od = '0;
                n_ok = r_kind; n_ov = 1'b1; n_state = isaac_pkg::S_IDLE;
            end
            isaac_pkg::S_PRE_MIX: begin
                n_iw = isaac_pkg::mix_step(r_iw, r_j[2:0]);
                n_j = r_j + 4'd1;
                if (r_j[2:0] == 3'd7) begin
                    if (r_i == W'(3)) begin
                        n_i = '0; n_pass = 1'b0; n_j = '0;
                        n_state = isaac_pkg::S_MP_RD;
                    end else n_i = r_i + 1'b1;
                end
            end
            isaac_pkg::S_MP_RD: begin
                m_addr = w_group; s_addr = w_group;
                n_state = isaac_pkg::S_MP_RDW;
            end
            // hold the address so the read data stays on the group word
            isaac_pkg::S_MP_RDW: begin
                m_addr = w_group; s_addr = w_group;
                n_state = isaac_pkg::S_MP_ADD;
            end
            isaac_pkg::S_MP_ADD: begin
                n_iw[r_j[2:0]*32 +: 32] = r_iw[r_j[2:0]*32 +: 32] + (r_pass ? m_rd : s_rd);
                if (r_j[2:0] == 3'd7) begin
                    n_j = '0; n_state = isaac_pkg::S_MP_MIX;
                end else begin
                    n_j = r_j + 4'd1; n_state = isaac_pkg::S_MP_RD;
                end
            end
            isaac_pkg::S_MP_MIX: begin
                n_iw = isaac_pkg::mix_step(r_iw, r_j[2:0]);
                n_j = r_j + 4'd1;
                if (r_j[2:0] == 3'd7) begin
                    n_j = '0; n_state = isaac_pkg::S_MP_WR;
                end
            end
            isaac_pkg::S_MP_WR: begin
                m_we = 1'b1; m_addr = w_group; m_wd = r_iw[r_j[2:0]*32 +: 32];
                n_j = r_j + 4'd1;
                if (r_j[2:0] == 3'd7) begin
                    n_j = '0; n_i = r_i + W'(8);
                    n_state = isaac_pkg::S_MP_RD;
                    if (r_i == W'(isaac_pkg::WORD_COUNT - 8)) begin
                        n_i = '0; n_pass = 1'b1;
                        if (r_pass) n_state = isaac_pkg::S_G_START;
                    end
                end
            end
            isaac_pkg::S_G_START: begin
                n_cnt = r_cnt + 32'd1; n_b = r_b + r_cnt + 32'd1;
                n_i = '0; n_state = isaac_pkg::S_G_X;
            end
            isaac_pkg::S_G_X: begin
                m_addr = r_i; n_state = isaac_pkg::S_G_XW;
            end
            isaac_pkg::S_G_XW: begin
                n_x = m_rd;
                m_addr = r_i ^ W'(isaac_pkg::WORD_COUNT / 2);
                n_state = isaac_pkg::S_G_H;
            end
            isaac_pkg::S_G_H: begin
                n_a = m_rd + w_a1; m_addr = r_x[W+1:2];
                n_state = isaac_pkg::S_G_HW;
            end
            isaac_pkg::S_G_HW: begin
                n_y = m_rd + r_a + r_b;
                m_we = 1'b1; m_addr = r_i; m_wd = m_rd + r_a + r_b;
                n_state = isaac_pkg::S_G_Y;
            end
            isaac_pkg::S_G_Y: begin
                m_addr = r_y[W+9:10]; n_state = isaac_pkg::S_G_YW;
            end
            isaac_pkg::S_G_YW: begin
                n_b = m_rd + r_x;
                s_we = 1'b1; s_wd = m_rd + r_x;
                n_i = r_i + 1'b1;
                n_state = (r_i == W'(isaac_pkg::WORD_COUNT - 1)) ?
                          isaac_pkg::S_OUT : isaac_pkg::S_G_X;
            end
            default: n_state = isaac_pkg::S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ok;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != isaac_pkg::S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != isaac_pkg::REQ_READ) |-> (m_axis_tdata == 32'd0))
        else $error("nonzero data on non-read");
endmodule
